// File: design/sampled_trajectory_interpolator_core_defines.svh
// Assertion macros for the sampled trajectory interpolator.
// Included by the modules that assert; depends on nothing else.
`ifndef SAMPLED_TRAJECTORY_INTERPOLATOR_CORE_DEFINES_SVH
`define SAMPLED_TRAJECTORY_INTERPOLATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define STI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sti assertion failed");
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sti assertion failed");
`else
`define STI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/sti_pkg.sv
// Package for the sampled trajectory interpolator.
// Holds the transaction types, the state enum and fixed constants; no dependencies.
package sti_pkg;

    localparam int VALUE_W    = 32;
    localparam int NFIELDS    = 5;
    localparam int IDX_W      = 10;
    localparam int MAX_SAMPLES = 1 << IDX_W;
    localparam int DUR_W      = 31;
    localparam int FRAC_W     = 16;
    localparam int QUOT_W     = IDX_W + FRAC_W;
    localparam int PROD_W     = IDX_W + DUR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int KCNT_W     = 3;
    localparam int DCNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [DUR_W-1:0] DURATION_RST   = 31'd1000000;
    localparam logic [IDX_W-1:0] LAST_INDEX_RST = 10'd1;

    typedef logic [NFIELDS-1:0][VALUE_W-1:0] t_word;

    typedef struct packed {
        logic                      req_type;
        logic [IDX_W-1:0]          sample_index;
        logic signed [VALUE_W-1:0] in_pos_x;
        logic signed [VALUE_W-1:0] in_pos_y;
        logic signed [VALUE_W-1:0] in_pos_angle;
        logic signed [VALUE_W-1:0] in_lin_vel;
        logic signed [VALUE_W-1:0] in_ang_vel;
        logic signed [31:0]        query_time;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_pos_x;
        logic signed [VALUE_W-1:0] out_pos_y;
        logic signed [VALUE_W-1:0] out_pos_angle;
        logic signed [VALUE_W-1:0] out_lin_vel;
        logic signed [VALUE_W-1:0] out_ang_vel;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RD_LO,
        ST_RD_HI,
        ST_LERP
    } t_state;

endpackage

// File: design/sampled_trajectory_interpolator_core.sv
// Sampled trajectory interpolator: sample table, restoring divider and shared lerp multiplier.
// Depends on sti_pkg and sampled_trajectory_interpolator_core_defines.svh.
//
// A load transaction writes one sample in the cycle it is accepted and leaves the core ready.
// A query transaction keeps busy high while it runs and ends with one o_valid cycle: an
// interior time passes through a multiply step, the bit-serial divider, the low and high
// table reads and the shared lerp multiplier before o_valid; a time at or beyond either end
// of the trajectory skips the multiply step and the divider. The result holds on o_res
// until the next query reaches its lerp cycles, but o_valid marks it for one cycle only and
// the receiver cannot stall it. Every sample a query touches must be loaded.
`include "sampled_trajectory_interpolator_core_defines.svh"

module sampled_trajectory_interpolator_core
    import sti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_valid,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DUR_W-1:0]     i_cfg_data
);

    t_state r_state, n_state;

    logic [DUR_W-1:0]  r_duration;
    logic [IDX_W-1:0]  r_last_index;
    logic [DUR_W-1:0]  r_time;
    logic [DUR_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_src;
    logic [QUOT_W-1:0] r_quot;
    logic [DCNT_W-1:0] r_dcnt;
    logic [IDX_W-1:0]  r_lo_idx;
    logic [IDX_W-1:0]  r_hi_idx;
    logic [FRAC_W-1:0] r_w;
    logic [KCNT_W-1:0] r_k;
    t_word             r_rd_word;
    t_word             r_lo_word;
    logic signed [VALUE_W+FRAC_W+1:0] r_mult;
    t_word             r_res;
    logic              r_valid;
    t_word             r_mem [MAX_SAMPLES];

    logic                     w_accept;
    logic                     w_load;
    logic                     w_query;
    logic                     w_t_ge;
    logic                     w_t_le;
    logic [PROD_W-1:0]        w_p;
    logic [DUR_W+1:0]         w_trial;
    logic [QUOT_W-1:0]        w_quot_next;
    logic [DUR_W-1:0]         w_rem_next;
    logic                     w_rem_nz;
    logic [IDX_W-1:0]         w_rd_addr;
    logic [KCNT_W-1:0]        w_ksel;
    logic [KCNT_W-1:0]        w_kprev;
    logic signed [VALUE_W:0]  w_diff;
    logic signed [VALUE_W+FRAC_W+1:0] w_prod;
    logic signed [VALUE_W+1:0] w_sum;
    logic                     w_div_last;
    logic                     w_lerp_last;

    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_req.req_type == REQ_LOAD);
    assign w_query  = w_accept && (i_req.req_type == REQ_QUERY);

    assign w_t_ge = !i_req.query_time[31] && (i_req.query_time[DUR_W-1:0] >= r_duration);
    assign w_t_le = i_req.query_time[31] || (i_req.query_time == 32'sd0);

    assign w_p = PROD_W'(r_last_index) * PROD_W'(r_time);

    assign w_trial     = {1'b0, r_rem, r_src[QUOT_W-1]} - {2'b00, r_duration};
    assign w_quot_next = {r_quot[QUOT_W-2:0], !w_trial[DUR_W+1]};
    assign w_rem_next  = !w_trial[DUR_W+1] ? w_trial[DUR_W-1:0]
                                           : {r_rem[DUR_W-2:0], r_src[QUOT_W-1]};
    assign w_rem_nz    = (w_rem_next != '0) || (w_quot_next[FRAC_W-1:0] != '0);
    assign w_div_last  = (r_dcnt == DCNT_W'(QUOT_W - 1));
    assign w_lerp_last = (r_k == KCNT_W'(NFIELDS));

    assign w_ksel  = (r_k < KCNT_W'(NFIELDS)) ? r_k : '0;
    assign w_kprev = (r_k != '0) ? (r_k - 1'b1) : '0;
    assign w_diff  = $signed({r_rd_word[w_ksel][VALUE_W-1], r_rd_word[w_ksel]})
                   - $signed({r_lo_word[w_ksel][VALUE_W-1], r_lo_word[w_ksel]});
    assign w_prod  = w_diff * $signed({1'b0, r_w});
    assign w_sum   = $signed({{2{r_lo_word[w_kprev][VALUE_W-1]}}, r_lo_word[w_kprev]})
                   + $signed(r_mult[VALUE_W+FRAC_W+1:FRAC_W]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = (w_t_ge || w_t_le) ? ST_RD_LO : ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_last) begin
                    n_state = ST_RD_LO;
                end
            end
            ST_RD_LO: n_state = ST_RD_HI;
            ST_RD_HI: n_state = ST_LERP;
            ST_LERP: begin
                if (w_lerp_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        w_rd_addr = r_hi_idx;
        case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_RD_LO: w_rd_addr = r_lo_idx;
            default:  w_rd_addr = r_hi_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_duration   <= DURATION_RST;
            r_last_index <= LAST_INDEX_RST;
            r_valid      <= 1'b0;
            r_dcnt       <= '0;
            r_k          <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_LERP) && w_lerp_last;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DURATION:   r_duration <= i_cfg_data;
                    CFG_LAST_INDEX: r_last_index <= i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_DIV) begin
                r_dcnt <= r_dcnt + 1'b1;
            end else begin
                r_dcnt <= '0;
            end
            if (r_state == ST_LERP) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_time <= i_req.query_time[DUR_W-1:0];
            r_w    <= '0;
            if (w_t_ge) begin
                r_lo_idx <= r_last_index;
                r_hi_idx <= r_last_index;
            end else begin
                r_lo_idx <= '0;
                r_hi_idx <= '0;
            end
        end
        if (r_state == ST_MUL) begin
            r_rem  <= w_p[PROD_W-1:IDX_W];
            r_src  <= {w_p[IDX_W-1:0], {FRAC_W{1'b0}}};
            r_quot <= '0;
        end
        if (r_state == ST_DIV) begin
            r_src  <= {r_src[QUOT_W-2:0], 1'b0};
            r_quot <= w_quot_next;
            r_rem  <= w_rem_next;
            if (w_div_last) begin
                r_lo_idx <= w_quot_next[QUOT_W-1:FRAC_W];
                r_hi_idx <= w_quot_next[QUOT_W-1:FRAC_W] + IDX_W'(w_rem_nz);
                r_w      <= w_quot_next[FRAC_W-1:0];
            end
        end
        if (r_state == ST_RD_HI) begin
            r_lo_word <= r_rd_word;
        end
        if (r_state == ST_LERP) begin
            r_mult <= w_prod;
            if (r_k != '0) begin
                r_res[w_kprev] <= w_sum[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[i_req.sample_index] <= {i_req.in_ang_vel, i_req.in_lin_vel,
                                          i_req.in_pos_angle, i_req.in_pos_y,
                                          i_req.in_pos_x};
        end
        r_rd_word <= r_mem[w_rd_addr];
    end

    assign o_valid             = r_valid;
    assign o_res.out_pos_x     = r_res[0];
    assign o_res.out_pos_y     = r_res[1];
    assign o_res.out_pos_angle = r_res[2];
    assign o_res.out_lin_vel   = r_res[3];
    assign o_res.out_ang_vel   = r_res[4];

    `STI_ASSERT_SAME(a_valid_when_idle, i_clk, i_rst_n, o_valid, r_state == ST_IDLE)
    `STI_ASSERT_NEXT(a_valid_one_cycle, i_clk, i_rst_n, o_valid, !o_valid)
    `STI_ASSERT_NEXT(a_query_goes_busy, i_clk, i_rst_n, w_query, busy)
    `STI_ASSERT_NEXT(a_load_stays_ready, i_clk, i_rst_n, w_load, !busy)
    `STI_ASSERT_SAME(a_div_count_bound, i_clk, i_rst_n, r_state == ST_DIV, r_dcnt <= DCNT_W'(QUOT_W - 1))

endmodule

// File: tb/tb_sampled_trajectory_interpolator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sampled trajectory interpolator core.
// Mirrors the sample table and the lerp arithmetic in a small class and checks every result.
// Depends on sti_pkg and the core RTL only.

class trajectory_mirror;
    longint duration_q;
    longint last_idx;
    sti_pkg::t_word samples[sti_pkg::MAX_SAMPLES];
    bit loaded[sti_pkg::MAX_SAMPLES];
    sti_pkg::t_res pending_poses[$];
    int errors;
    int n_loads;
    int n_queries;
    int n_interp;
    int n_checked;

    function new();
        duration_q = sti_pkg::DURATION_RST;
        last_idx = sti_pkg::LAST_INDEX_RST;
        foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_config(longint dur, longint last);
        duration_q = dur;
        last_idx = last;
    endfunction

    function int pending();
        return pending_poses.size();
    endfunction

    // Finds the two neighboring samples and the weight for a query time.
    function void locate(input logic signed [31:0] t, output int lo, output int hi,
                         output longint w, output bit interp);
        longint tt;
        longint p;
        longint q;
        longint r;
        tt = t;
        w = 0;
        interp = 1'b0;
        if (tt >= duration_q) begin
            lo = int'(last_idx);
            hi = lo;
        end else if (tt <= 0) begin
            lo = 0;
            hi = 0;
        end else begin
            p = last_idx * tt;
            q = p / duration_q;
            r = p % duration_q;
            w = (r <<< sti_pkg::FRAC_W) / duration_q;
            lo = int'(q);
            hi = (r != 0) ? int'(q) + 1 : int'(q);
            interp = 1'b1;
        end
    endfunction

    function void note_accepted(sti_pkg::t_req r);
        int lo;
        int hi;
        int k;
        longint w;
        longint a;
        longint b;
        longint v;
        bit interp;
        sti_pkg::t_word pose;
        if (r.req_type == sti_pkg::REQ_LOAD) begin
            samples[r.sample_index] = {r.in_pos_x, r.in_pos_y, r.in_pos_angle,
                                       r.in_lin_vel, r.in_ang_vel};
            loaded[r.sample_index] = 1'b1;
            n_loads++;
        end else begin
            locate(r.query_time, lo, hi, w, interp);
            for (k = 0; k < sti_pkg::NFIELDS; k++) begin
                a = $signed(samples[lo][k]);
                b = $signed(samples[hi][k]);
                v = interp ? a + (((b - a) * w) >>> sti_pkg::FRAC_W) : a;
                pose[k] = v[31:0];
            end
            pending_poses = {pending_poses, sti_pkg::t_res'(pose)};
            n_queries++;
            if (interp) n_interp++;
        end
    endfunction

    function void check_pose(sti_pkg::t_res got);
        sti_pkg::t_word g;
        sti_pkg::t_word e;
        int k;
        string field_name[sti_pkg::NFIELDS] = '{"ang_vel", "lin_vel", "pos_angle", "pos_y",
                                                "pos_x"};
        if (pending_poses.size() == 0) begin
            $display("%0t: result with no query outstanding: %h", $time, got);
            errors++;
            return;
        end
        e = sti_pkg::t_word'(pending_poses.pop_front());
        g = sti_pkg::t_word'(got);
        n_checked++;
        for (k = 0; k < sti_pkg::NFIELDS; k++) begin
            if (g[k] !== e[k]) begin
                $display("%0t: out_%s mismatch, expected %0d (%h), got %0d (%h)", $time,
                         field_name[k], $signed(e[k]), e[k], $signed(g[k]), g[k]);
                errors++;
            end
        end
    endfunction
endclass

module tb_sampled_trajectory_interpolator_core;
    import sti_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 36;
    localparam int N_PHASES = 9;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_valid;
    t_res                 o_res;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DUR_W-1:0]     i_cfg_data = '0;

    trajectory_mirror mirror;
    int burst_left = 1;
    int idle_cycles = 0;
    int n_settings = 0;

    sampled_trajectory_interpolator_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) mirror.check_pose(o_res);
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.req_type = 1'($urandom_range(0, 1));
        r.sample_index = IDX_W'($urandom_range(0, MAX_SAMPLES - 1));
        r.in_pos_x = rand_value();
        r.in_pos_y = rand_value();
        r.in_pos_angle = rand_value();
        r.in_lin_vel = rand_value();
        r.in_ang_vel = rand_value();
        r.query_time = $urandom();
        return r;
    endfunction

    function automatic logic signed [31:0] pick_time();
        int unsigned sel;
        longint d;
        longint li;
        longint tv;
        sel = $urandom_range(0, 19);
        d = mirror.duration_q;
        li = mirror.last_idx;
        if (d >= 2 && sel < 12) return $urandom_range(1, 32'(d - 1));
        if (d >= 2 && li >= 1 && sel < 15) begin
            tv = (d * $urandom_range(0, 32'(li))) / li;
            return tv[31:0];
        end
        case (sel)
            15: return 32'sd0;
            16: return -$signed(32'($urandom_range(1, 1000)));
            17: begin
                tv = d + $urandom_range(0, 1000);
                return (tv > 64'sd2147483647) ? 32'h7fff_ffff : tv[31:0];
            end
            18: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Holds start high until the core takes the transaction, then maybe pauses the sender.
    task automatic send_item(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        mirror.note_accepted(r);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic load_sample(input int idx, input bit uniform, input logic [31:0] value);
        t_req r;
        r = rand_req();
        r.req_type = REQ_LOAD;
        r.sample_index = IDX_W'(idx);
        if (uniform) begin
            r.in_pos_x = value;
            r.in_pos_y = value;
            r.in_pos_angle = value;
            r.in_lin_vel = value;
            r.in_ang_vel = value;
        end
        send_item(r);
    endtask

    // Loads any sample the query would touch that has never been written.
    task automatic query_at(input logic signed [31:0] t);
        t_req r;
        int lo;
        int hi;
        longint w;
        bit interp;
        mirror.locate(t, lo, hi, w, interp);
        if (!mirror.loaded[lo]) load_sample(lo, 1'b0, '0);
        if (!mirror.loaded[hi]) load_sample(hi, 1'b0, '0);
        r = rand_req();
        r.req_type = REQ_QUERY;
        r.query_time = t;
        send_item(r);
    endtask

    task automatic write_config(input logic [DUR_W-1:0] dur, input logic [IDX_W-1:0] last);
        start <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DURATION;
        i_cfg_data <= dur;
        @(posedge i_clk);
        i_cfg_idx <= CFG_LAST_INDEX;
        i_cfg_data <= {{(DUR_W - IDX_W){1'b0}}, last};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.set_config(dur, last);
        n_settings++;
    endtask

    initial begin
        logic [DUR_W-1:0] phase_dur[N_PHASES];
        logic [IDX_W-1:0] phase_last[N_PHASES];
        int p;
        int n;
        mirror = new();
        phase_dur = '{31'h7fff_ffff, 31'd1, 31'd0, 31'd0, 31'd1000, 31'd4000,
                      31'($urandom_range(2, 100000)), 31'($urandom_range(1, 32'h7fff_ffff)),
                      DURATION_RST};
        phase_last = '{10'd1023, 10'd1, 10'd0, 10'd9, 10'd0, 10'd8,
                       10'($urandom_range(1, 40)), 10'($urandom_range(1, 1023)),
                       LAST_INDEX_RST};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: full-scale span in both directions, ends and beyond.
        load_sample(0, 1'b1, 32'h8000_0000);
        load_sample(1, 1'b1, 32'h7fff_ffff);
        query_at(32'h8000_0000);
        query_at(32'sd0);
        query_at(32'sd1);
        query_at(32'sd500000);
        query_at(32'sd999999);
        query_at(32'sd1000000);
        query_at(32'h7fff_ffff);
        load_sample(0, 1'b1, 32'h7fff_ffff);
        load_sample(1, 1'b1, 32'h8000_0000);
        query_at(32'sd1);
        query_at(32'sd250000);
        query_at(32'sd999999);
        load_sample(MAX_SAMPLES - 1, 1'b1, 32'h5555_5555);
        load_sample(512, 1'b0, '0);
        load_sample(0, 1'b1, 32'h0000_0000);
        load_sample(1, 1'b0, '0);
        query_at(32'sd123457);
        query_at(32'sd999998);

        for (p = 0; p < N_PHASES; p++) begin
            write_config(phase_dur[p], phase_last[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 30)
                    load_sample($urandom_range(0, 1) ? $urandom_range(0, 32'(mirror.last_idx))
                                                     : $urandom_range(0, MAX_SAMPLES - 1),
                                1'b0, '0);
                else
                    query_at(pick_time());
            end
        end

        start <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d loads and %0d queries across %0d register settings.",
                 mirror.n_loads, mirror.n_queries, n_settings + 1);
        $display("Checked %0d results, %0d of them interpolated between two samples.",
                 mirror.n_checked, mirror.n_interp);
        if (mirror.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
